// ===== hw/rtl/upd_pkg.sv =====
// shared types, constants and helpers for the url path percent-decode checker
`default_nettype none

package upd_pkg;

  // longest decoded path that is accepted
  localparam int unsigned PATH_MAX = 256;
  localparam int unsigned CNT_W    = $clog2(PATH_MAX + 1);

  // byte codes the checker looks at
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BSL   = 8'h5c;

  // verdict codes, ranked so decoding errors may replace a traversal error
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_ESCAPE = 3'd1,
    ERR_BYTE   = 3'd2,
    ERR_LONG   = 3'd3,
    ERR_TRAV   = 3'd4
  } err_kind_t;

  // position inside a %XX escape
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       finished;
    logic       accepted;
    err_kind_t  error_kind;
    logic       empty_default;
  } result_t;

  // hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] v;
    logic [4:0] r;
    v = 8'h00;
    r = 5'h00;
    if (b inside {[8'h30:8'h39]}) begin
      v = b - 8'h30;
      r = {1'b1, v[3:0]};
    end else if (b inside {[8'h61:8'h66]}) begin
      v = b - 8'h57;
      r = {1'b1, v[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      v = b - 8'h37;
      r = {1'b1, v[3:0]};
    end
    return r;
  endfunction

  // control bytes, delete and backslash are never allowed in a path
  function automatic logic is_forbidden(input logic [7:0] c);
    return (c < CH_SPACE) || (c == CH_DEL) || (c == CH_BSL);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/upd_if.sv =====
// valid/ready channel interfaces for path bytes in and decoded results out
`default_nettype none

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output path_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input path_byte, input has_byte, input last,
                output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       finished;
  logic       accepted;
  logic [2:0] error_kind;
  logic       empty_default;

  modport source (output valid, output out_byte, output out_valid, output finished,
                  output accepted, output error_kind, output empty_default,
                  input ready);
  modport sink (input valid, input out_byte, input out_valid, input finished,
                input accepted, input error_kind, input empty_default,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/url_path_percent_decode_check.sv =====
// URL path percent-decode checker: bytes in, one result transaction per input transaction out
//
// Usage: the in channel carries one raw path byte per transaction (has_byte
// clear for an end marker with no byte, last set on the final transaction of
// a path). The out channel returns exactly one result per input transaction,
// in order: a decoded byte when out_valid is set, and on the result of the
// last transaction the verdict (finished, accepted, error_kind, empty_default).
// A raw '?' or '#' ends the path; later bytes give empty results.
// A result passes from the input register through the step logic into the
// result register and is offered from there; a stall can hold it in either.
// Throughput: one transaction per cycle; the input register feeds the result
// register directly, and in.ready stays high while the result register is
// free or being taken in the same cycle.
// Stall: when the receiver holds ready low, the result register holds, the
// input register fills, and then in.ready falls until the result is taken.
// Reset (rst, synchronous): empties both registers and returns the path
// state to the start of a new path.
`default_nettype none

module url_path_percent_decode_check
  import upd_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);

  logic     in_vld;
  in_item_t in_item;
  logic     out_vld;
  result_t  out_res;
  result_t  step_res;
  logic     advance;

  // the held transaction moves to the result register when that one is free
  assign advance     = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = !in_vld || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item.path_byte <= in_ch.path_byte;
      in_item.has_byte  <= in_ch.has_byte;
      in_item.last      <= in_ch.last;
    end
  end

  upd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (in_item),
    .res     (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign out_ch.valid         = out_vld;
  assign out_ch.out_byte      = out_res.out_byte;
  assign out_ch.out_valid     = out_res.out_valid;
  assign out_ch.finished      = out_res.finished;
  assign out_ch.accepted      = out_res.accepted;
  assign out_ch.error_kind    = 3'(out_res.error_kind);
  assign out_ch.empty_default = out_res.empty_default;

endmodule

`default_nettype wire

// ===== hw/rtl/upd_core.sv =====
// decode and check state with the single-pass step logic for one path byte
`default_nettype none

module upd_core
  import upd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step_en,
  input  wire in_item_t item,
  output result_t       res
);

  // path state
  esc_phase_t       esc;
  logic [3:0]       high_nibble;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       prev_byte;
  logic [7:0]       prev_prev_byte;
  logic             stopped;
  err_kind_t        err;

  esc_phase_t       esc_next;
  logic [3:0]       high_nibble_next;
  logic [CNT_W-1:0] cnt_next;
  logic [7:0]       prev_byte_next;
  logic [7:0]       prev_prev_byte_next;
  logic             stopped_next;
  err_kind_t        err_next;

  logic             decode_ok;
  logic [4:0]       hex;
  logic             have_c;
  logic [7:0]       c;

  assign decode_ok = (err == ERR_NONE) || (err == ERR_TRAV);
  assign hex       = hex_decode(item.path_byte);

  // escape handling: produce a decoded byte or advance the escape phase
  always_comb begin
    esc_next         = esc;
    high_nibble_next = high_nibble;
    stopped_next     = stopped;
    have_c           = 1'b0;
    c                = item.path_byte;
    if (item.has_byte && !stopped && decode_ok) begin
      case (esc)
        ESC_NONE: begin
          if (item.path_byte == CH_QMARK || item.path_byte == CH_HASH) begin
            stopped_next = 1'b1;
          end else if (item.path_byte == CH_PCT) begin
            esc_next = ESC_HIGH;
          end else begin
            have_c = 1'b1;
          end
        end
        ESC_HIGH: begin
          if (hex[4]) begin
            high_nibble_next = hex[3:0];
            esc_next         = ESC_LOW;
          end else begin
            esc_next = ESC_NONE;
          end
        end
        ESC_LOW: begin
          esc_next = ESC_NONE;
          if (hex[4]) begin
            have_c = 1'b1;
            c      = {high_nibble, hex[3:0]};
          end
        end
        default: begin
          esc_next = ESC_NONE;
        end
      endcase
    end
  end

  // byte checks, traversal patterns and the verdict on the last transaction
  always_comb begin
    err_next            = err;
    cnt_next            = cnt;
    prev_byte_next      = prev_byte;
    prev_prev_byte_next = prev_prev_byte;
    res                 = '0;
    res.error_kind      = ERR_NONE;

    // a non-hex byte inside an escape
    if (item.has_byte && !stopped && decode_ok && esc != ESC_NONE && !hex[4]) begin
      err_next = ERR_ESCAPE;
    end

    if (have_c) begin
      if (is_forbidden(c)) begin
        err_next = ERR_BYTE;
      end else if (cnt >= CNT_W'(PATH_MAX)) begin
        err_next = ERR_LONG;
      end else begin
        if (err == ERR_NONE &&
            ((cnt == '0 && c == CH_SLASH) ||
             (prev_byte == CH_DOT && c == CH_SLASH) ||
             (prev_byte == CH_SLASH && c == CH_SLASH) ||
             (prev_prev_byte == CH_SLASH && prev_byte == CH_DOT && c == CH_DOT))) begin
          err_next = ERR_TRAV;
        end
        prev_prev_byte_next = prev_byte;
        prev_byte_next      = c;
        cnt_next            = cnt + 1'b1;
        if (err_next == ERR_NONE) begin
          res.out_byte  = c;
          res.out_valid = 1'b1;
        end
      end
    end

    if (item.last) begin
      // an escape cut off by the end of the path
      if (esc_next != ESC_NONE && (err_next == ERR_NONE || err_next == ERR_TRAV)) begin
        err_next = ERR_ESCAPE;
      end
      if (err_next == ERR_NONE && cnt_next == CNT_W'(2) &&
          prev_prev_byte_next == CH_DOT && prev_byte_next == CH_DOT) begin
        err_next = ERR_TRAV;
      end
      res.finished      = 1'b1;
      res.error_kind    = err_next;
      res.accepted      = (err_next == ERR_NONE);
      res.empty_default = (err_next == ERR_NONE) && (cnt_next == '0);
    end
  end

  // state update, cleared after the last transaction of a path
  always_ff @(posedge clk) begin
    if (rst) begin
      esc            <= ESC_NONE;
      high_nibble    <= '0;
      cnt            <= '0;
      prev_byte      <= '0;
      prev_prev_byte <= '0;
      stopped        <= 1'b0;
      err            <= ERR_NONE;
    end else if (step_en) begin
      if (item.last) begin
        esc            <= ESC_NONE;
        high_nibble    <= '0;
        cnt            <= '0;
        prev_byte      <= '0;
        prev_prev_byte <= '0;
        stopped        <= 1'b0;
        err            <= ERR_NONE;
      end else begin
        esc            <= esc_next;
        high_nibble    <= high_nibble_next;
        cnt            <= cnt_next;
        prev_byte      <= prev_byte_next;
        prev_prev_byte <= prev_prev_byte_next;
        stopped        <= stopped_next;
        err            <= err_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(PATH_MAX))
    else $error("decoded count above path limit");

  a_emit_counts: assert property (@(posedge clk) disable iff (rst)
    step_en && res.out_valid && !item.last |=> cnt != '0)
    else $error("byte put out without being counted");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step_en && item.last |=> cnt == '0 && esc == ESC_NONE && !stopped && err == ERR_NONE)
    else $error("path state not cleared after last transaction");

  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    res.accepted |-> res.finished && res.error_kind == ERR_NONE)
    else $error("accepted verdict with an error code");

  a_err_no_emit: assert property (@(posedge clk) disable iff (rst)
    err != ERR_NONE |-> !res.out_valid)
    else $error("byte put out after an error");
`endif

endmodule

`default_nettype wire
